FILE: hdl/pst_pkg.sv
// Package for the point slot table: field widths, operation and status codes,
// sequencer state type and the sequencer-to-datapath control struct.
// No dependencies.
package pst_pkg;

    // Default number of slots in the table.
    localparam int SLOTS_DEFAULT = 16;

    // Field widths of the request and result items.
    localparam int MODE_W   = 3;
    localparam int COORD_W  = 16;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_ADD      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RM_FIRST = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RM_LAST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RM_IDX   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RM_X     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FIND_Y   = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_SLOT_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NO_MATCH   = 3'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } seq_state_t;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic rd_en;   // read one slot's coordinates this cycle
        logic eval;    // read data of the previous slot is valid
        logic fin;     // scan complete, result is being formed
    } ctrl_t;

endpackage

FILE: hdl/pst_req_if.sv
// Request channel of the point slot table: valid/ready handshake plus payload.
// Depends on pst_pkg for field widths.
interface pst_req_if;

    logic                               valid;
    logic                               ready;
    logic [pst_pkg::MODE_W-1:0]         mode;
    logic signed [pst_pkg::COORD_W-1:0] x_value;
    logic signed [pst_pkg::COORD_W-1:0] y_value;
    logic [pst_pkg::IDX_W-1:0]          slot_index;

    modport source (output valid, mode, x_value, y_value, slot_index, input ready);
    modport sink   (input valid, mode, x_value, y_value, slot_index, output ready);

endinterface

FILE: hdl/pst_rsp_if.sv
// Result channel of the point slot table: valid/ready handshake plus payload.
// Depends on pst_pkg for field widths.
interface pst_rsp_if;

    logic                               valid;
    logic                               ready;
    logic [pst_pkg::STATUS_W-1:0]       status;
    logic [pst_pkg::IDX_W-1:0]          hit_index;
    logic signed [pst_pkg::COORD_W-1:0] hit_x;
    logic signed [pst_pkg::COORD_W-1:0] hit_y;
    logic [pst_pkg::COUNT_W-1:0]        entries_held;
    logic [pst_pkg::COUNT_W-1:0]        removed_count;

    modport source (output valid, status, hit_index, hit_x, hit_y, entries_held,
                    removed_count, input ready);
    modport sink   (input valid, status, hit_index, hit_x, hit_y, entries_held,
                    removed_count, output ready);

endinterface

FILE: hdl/pst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/pst_ctrl.sv
// Scan sequencer of the point slot table: walks all slots once per request,
// issuing one RAM read a cycle and flagging the cycle its data is evaluated.
// Depends on pst_pkg.
module pst_ctrl #(
    parameter int SLOTS = pst_pkg::SLOTS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     rev,
    input  logic                     out_free,
    output logic                     idle,
    output pst_pkg::ctrl_t           ctrl,
    output logic [$clog2(SLOTS)-1:0] rd_addr,
    output logic [$clog2(SLOTS)-1:0] ev_addr
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
    localparam logic [CW-1:0] SCAN_END  = CW'(SLOTS);

    pst_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                ev_valid_reg;
    logic [AW-1:0]       ev_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pst_pkg::S_IDLE;
            cnt_reg      <= '0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ev_valid_reg <= ctrl.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_addr_reg <= rd_addr;
    end

    // Remove-last walks the table from the top down.
    assign rd_addr = rev ? (LAST_SLOT - cnt_reg[AW-1:0]) : cnt_reg[AW-1:0];
    assign ev_addr = ev_addr_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        idle       = 1'b0;
        unique case (state_reg)
            pst_pkg::S_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    cnt_next   = '0;
                    state_next = pst_pkg::S_SCAN;
                end
            end
            pst_pkg::S_SCAN:
            begin
                if (cnt_reg != SCAN_END)
                begin
                    ctrl.rd_en = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
                else if (!ev_valid_reg)
                begin
                    state_next = pst_pkg::S_FIN;
                end
            end
            pst_pkg::S_FIN:
            begin
                ctrl.fin = 1'b1;
                if (out_free)
                begin
                    state_next = pst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pst_pkg::S_IDLE;
            end
        endcase
        ctrl.eval = ev_valid_reg;
    end

endmodule

FILE: hdl/point_slot_table_top.sv
// Top level of the point slot table: valid bits, entry count, shared compare
// unit, result register. Depends on pst_pkg, pst_req_if, pst_rsp_if, pst_ram
// and pst_ctrl.

// The point slot table holds SLOTS slots of signed 16-bit (x, y) points, each
// with a valid bit, and serves one request at a time: add, remove first,
// remove last, remove at index, remove by x, or find by y. Each request gives
// exactly one result carrying a status, the slot touched, its coordinates,
// the entry count afterwards and how many slots were cleared. A request is
// handled by one full walk over the table: the coordinates live in a RAM with
// a single read port, and a sequencer reads one slot per cycle while a single
// 16-bit comparator checks it against the key. From acceptance, the sequencer
// reads every slot in turn, waits for the last read data, closes the scan and
// loads the result register; the request side is not ready during that time.
// The result sits in an output register, so the next request is taken as soon
// as the walk finishes even if the previous result has not yet been collected;
// the sequencer only holds at the end of a walk while that register is full.
// Errors (full table, empty table, empty named slot, no match) return a status
// and leave the table unchanged. No clearing pass is needed after reset: the
// valid bits reset to empty and coordinates are only read from valid slots.
module point_slot_table_top #(
    parameter int SLOTS = pst_pkg::SLOTS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    pst_req_if.sink    req,
    pst_rsp_if.source  rsp
);

    localparam int AW   = $clog2(SLOTS);
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int HW   = (AW > pst_pkg::IDX_W) ? AW : pst_pkg::IDX_W;
    localparam int NW   = (CW > pst_pkg::COUNT_W) ? CW : pst_pkg::COUNT_W;
    localparam int XY_W = 2 * pst_pkg::COORD_W;

    // Captured request.
    logic [pst_pkg::MODE_W-1:0]  mode_reg;
    logic [pst_pkg::COORD_W-1:0] x_reg;
    logic [pst_pkg::COORD_W-1:0] y_reg;
    logic [pst_pkg::IDX_W-1:0]   idx_reg;

    // Table state.
    logic [SLOTS-1:0] valid_reg;
    logic [CW-1:0]    count_reg;

    // Scan accumulators.
    logic                        found_reg;
    logic [CW-1:0]               removed_reg;
    logic [AW-1:0]               hit_idx_reg;
    logic [pst_pkg::COORD_W-1:0] hit_x_reg;
    logic [pst_pkg::COORD_W-1:0] hit_y_reg;

    // Result register.
    logic                         out_valid_reg;
    logic [pst_pkg::STATUS_W-1:0] status_out_reg;
    logic [pst_pkg::IDX_W-1:0]    hit_index_out_reg;
    logic [pst_pkg::COORD_W-1:0]  hit_x_out_reg;
    logic [pst_pkg::COORD_W-1:0]  hit_y_out_reg;
    logic [pst_pkg::COUNT_W-1:0]  entries_out_reg;
    logic [pst_pkg::COUNT_W-1:0]  removed_out_reg;

    pst_pkg::ctrl_t ctrl;
    logic           idle;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  ev_addr;
    logic [XY_W-1:0] rd_data;

    logic accept;
    logic out_free;
    logic fin_fire;
    logic add_commit;
    logic rev;

    logic                        vbit;
    logic [pst_pkg::COORD_W-1:0] rx;
    logic [pst_pkg::COORD_W-1:0] ry;
    logic [pst_pkg::COORD_W-1:0] cmp_key;
    logic [pst_pkg::COORD_W-1:0] cmp_field;
    logic                        key_eq;
    logic                        idx_eq;
    logic                        match;
    logic                        is_remove;
    logic                        take;
    logic [pst_pkg::STATUS_W-1:0] miss_status;

    logic [CW-1:0] entries_after;
    logic [HW-1:0] hit_wide;
    logic [NW-1:0] ent_wide;
    logic [NW-1:0] rem_wide;

    assign accept    = req.valid && req.ready;
    assign req.ready = idle;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign fin_fire  = ctrl.fin && out_free;
    assign rev       = (mode_reg == pst_pkg::MODE_RM_LAST);

    // An add that found a free slot commits its write when the result is loaded into the result register.
    assign add_commit = (mode_reg == pst_pkg::MODE_ADD) && found_reg;

    pst_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .rev      (rev),
        .out_free (out_free),
        .idle     (idle),
        .ctrl     (ctrl),
        .rd_addr  (rd_addr),
        .ev_addr  (ev_addr)
    );

    pst_ram #(
        .WIDTH (XY_W),
        .DEPTH (SLOTS)
    ) u_xy_ram (
        .clk     (clk),
        .wr_en   (fin_fire && add_commit),
        .wr_addr (hit_idx_reg),
        .wr_data ({x_reg, y_reg}),
        .rd_en   (ctrl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The shared compare unit: one 16-bit equality check per scanned slot,
    // against x for remove-by-x and y for find-by-y.
    assign rx        = rd_data[XY_W-1:pst_pkg::COORD_W];
    assign ry        = rd_data[pst_pkg::COORD_W-1:0];
    assign vbit      = valid_reg[ev_addr];
    assign cmp_key   = (mode_reg == pst_pkg::MODE_FIND_Y) ? y_reg : x_reg;
    assign cmp_field = (mode_reg == pst_pkg::MODE_FIND_Y) ? ry : rx;
    assign key_eq    = (cmp_field == cmp_key);
    assign idx_eq    = (HW'(ev_addr) == HW'(idx_reg));

    always_comb
    begin
        match       = 1'b0;
        is_remove   = 1'b0;
        miss_status = pst_pkg::STAT_OK;
        unique case (mode_reg) inside
            pst_pkg::MODE_ADD:
            begin
                match       = !vbit;
                miss_status = pst_pkg::STAT_FULL;
            end
            pst_pkg::MODE_RM_FIRST, pst_pkg::MODE_RM_LAST:
            begin
                match       = vbit;
                is_remove   = 1'b1;
                miss_status = pst_pkg::STAT_EMPTY;
            end
            pst_pkg::MODE_RM_IDX:
            begin
                match       = vbit && idx_eq;
                is_remove   = 1'b1;
                miss_status = pst_pkg::STAT_SLOT_EMPTY;
            end
            pst_pkg::MODE_RM_X:
            begin
                match       = vbit && key_eq;
                is_remove   = 1'b1;
                miss_status = pst_pkg::STAT_NO_MATCH;
            end
            pst_pkg::MODE_FIND_Y:
            begin
                match       = vbit && key_eq;
                miss_status = pst_pkg::STAT_NO_MATCH;
            end
            default:
            begin
                match       = 1'b0;
                miss_status = pst_pkg::STAT_OK;
            end
        endcase
    end

    // Only remove-by-x acts on every match; the others stop at the first.
    assign take = ctrl.eval && match && (!found_reg || (mode_reg == pst_pkg::MODE_RM_X));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= pst_pkg::MODE_ADD;
            valid_reg   <= '0;
            count_reg   <= '0;
            found_reg   <= 1'b0;
            removed_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg    <= req.mode;
            found_reg   <= 1'b0;
            removed_reg <= '0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
            if (is_remove)
            begin
                valid_reg[ev_addr] <= 1'b0;
                count_reg          <= count_reg - 1'b1;
                removed_reg        <= removed_reg + 1'b1;
            end
        end
        else if (fin_fire && add_commit)
        begin
            valid_reg[hit_idx_reg] <= 1'b1;
            count_reg              <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg       <= req.x_value;
            y_reg       <= req.y_value;
            idx_reg     <= req.slot_index;
            hit_idx_reg <= '0;
            hit_x_reg   <= '0;
            hit_y_reg   <= '0;
        end
        else if (take && !found_reg)
        begin
            hit_idx_reg <= ev_addr;
            hit_x_reg   <= (mode_reg == pst_pkg::MODE_ADD) ? x_reg : rx;
            hit_y_reg   <= (mode_reg == pst_pkg::MODE_ADD) ? y_reg : ry;
        end
    end

    // Result fields keep only the low bits of their widths for large tables.
    assign entries_after = add_commit ? (count_reg + 1'b1) : count_reg;
    assign hit_wide      = HW'(hit_idx_reg);
    assign ent_wide      = NW'(entries_after);
    assign rem_wide      = NW'(removed_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            status_out_reg    <= found_reg ? pst_pkg::STAT_OK : miss_status;
            hit_index_out_reg <= hit_wide[pst_pkg::IDX_W-1:0];
            hit_x_out_reg     <= hit_x_reg;
            hit_y_out_reg     <= hit_y_reg;
            entries_out_reg   <= ent_wide[pst_pkg::COUNT_W-1:0];
            removed_out_reg   <= rem_wide[pst_pkg::COUNT_W-1:0];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_out_reg;
    assign rsp.hit_index     = hit_index_out_reg;
    assign rsp.hit_x         = hit_x_out_reg;
    assign rsp.hit_y         = hit_y_out_reg;
    assign rsp.entries_held  = entries_out_reg;
    assign rsp.removed_count = removed_out_reg;

    // The entry count always agrees with the number of valid bits.
    a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == count_reg)
        else $error("entry count differs from number of valid slots");

    // The table never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("entry count exceeds table size");

    // Only remove-by-x may clear more than one slot in one request.
    a_single_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != pst_pkg::MODE_RM_X) |-> (removed_reg <= CW'(1)))
        else $error("several slots cleared by a single-slot removal");

    // A new result only appears at the end of a completed scan.
    a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.fin))
        else $error("result loaded outside the end of a scan");

endmodule

FILE: sim/point_slot_table_top_tb.sv
// Self-checking testbench for point_slot_table_top: directed table walk, then random requests.
// Depends on pst_pkg, pst_req_if, pst_rsp_if and the point_slot_table_top RTL.
module point_slot_table_top_tb;

    // The block takes a new request only after the walk for the previous one has finished and
    // its result has been loaded into the output register.
    localparam int TABLE_SLOTS     = pst_pkg::SLOTS_DEFAULT;
    localparam int SCAN_CYCLES     = TABLE_SLOTS + 3;
    localparam int RANDOM_REQUESTS = 1500;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASE_LENGTH    = 80;
    localparam int CNT_W           = pst_pkg::COUNT_W;
    // Allows about 4x the slowest correct run of roughly 1550 requests, with a clock period of
    // 8 time units.
    localparam int RUN_LIMIT       = 7_000_000;

    // Modes six and seven carry no operation; the block must answer them with an empty result.
    localparam logic [pst_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [pst_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [pst_pkg::MODE_W-1:0]         mode;
        logic signed [pst_pkg::COORD_W-1:0] x_value;
        logic signed [pst_pkg::COORD_W-1:0] y_value;
        logic [pst_pkg::IDX_W-1:0]          slot_index;
    } point_req_t;

    typedef struct packed {
        logic [pst_pkg::STATUS_W-1:0]       status;
        logic [pst_pkg::IDX_W-1:0]          hit_index;
        logic signed [pst_pkg::COORD_W-1:0] hit_x;
        logic signed [pst_pkg::COORD_W-1:0] hit_y;
        logic [pst_pkg::COUNT_W-1:0]        entries_held;
        logic [pst_pkg::COUNT_W-1:0]        removed_count;
    } slot_result_t;

    // One line of the directed script. A row with a typed result is checked against that
    // value; all other rows are checked against the predictor.
    typedef struct {
        point_req_t   req;
        int           reps;
        bit           typed;
        slot_result_t want;
    } script_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pst_req_if req();
    pst_rsp_if rsp();

    point_slot_table_top #(
        .SLOTS(TABLE_SLOTS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #4 clk = ~clk;

    // Shadow copy of the table, updated at the moment each request is accepted.
    bit                                 table_valid [TABLE_SLOTS];
    logic signed [pst_pkg::COORD_W-1:0] table_x     [TABLE_SLOTS];
    logic signed [pst_pkg::COORD_W-1:0] table_y     [TABLE_SLOTS];
    int                                 table_count;

    slot_result_t results_due[$];
    script_row_t  directed_rows[$];
    int           mismatch_count = 0;
    int           accepted_count = 0;
    int           cycle_count    = 0;
    bit           rsp_hold       = 1'b0;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Applies one request to the shadow table and returns the result it must produce.
    // Slot coordinates are only ever read from valid slots.
    task automatic table_op_predict(input point_req_t r, output slot_result_t res);
        bit found;
        int s;
        found = 1'b0;
        res   = '0;
        case (r.mode)
            pst_pkg::MODE_ADD:
            begin
                for (int k = 0; k < TABLE_SLOTS && !found; k++)
                begin
                    if (!table_valid[k])
                    begin
                        table_valid[k] = 1'b1;
                        table_x[k]     = r.x_value;
                        table_y[k]     = r.y_value;
                        table_count++;
                        res.hit_index  = k[pst_pkg::IDX_W-1:0];
                        res.hit_x      = r.x_value;
                        res.hit_y      = r.y_value;
                        found          = 1'b1;
                    end
                end
                if (!found)
                    res.status = pst_pkg::STAT_FULL;
            end
            pst_pkg::MODE_RM_FIRST, pst_pkg::MODE_RM_LAST:
            begin
                for (int k = 0; k < TABLE_SLOTS && !found; k++)
                begin
                    s = (r.mode == pst_pkg::MODE_RM_FIRST) ? k : TABLE_SLOTS - 1 - k;
                    if (table_valid[s])
                    begin
                        res.hit_index     = s[pst_pkg::IDX_W-1:0];
                        res.hit_x         = table_x[s];
                        res.hit_y         = table_y[s];
                        res.removed_count = CNT_W'(1);
                        table_valid[s]    = 1'b0;
                        table_count--;
                        found             = 1'b1;
                    end
                end
                if (!found)
                    res.status = pst_pkg::STAT_EMPTY;
            end
            pst_pkg::MODE_RM_IDX:
            begin
                s = int'(r.slot_index);
                if (s < TABLE_SLOTS && table_valid[s])
                begin
                    res.hit_index     = r.slot_index;
                    res.hit_x         = table_x[s];
                    res.hit_y         = table_y[s];
                    res.removed_count = CNT_W'(1);
                    table_valid[s]    = 1'b0;
                    table_count--;
                end
                else
                    res.status = pst_pkg::STAT_SLOT_EMPTY;
            end
            pst_pkg::MODE_RM_X:
            begin
                // Every matching slot goes; the lowest one is reported.
                for (int k = 0; k < TABLE_SLOTS; k++)
                begin
                    if (table_valid[k] && table_x[k] == r.x_value)
                    begin
                        if (!found)
                        begin
                            res.hit_index = k[pst_pkg::IDX_W-1:0];
                            res.hit_x     = table_x[k];
                            res.hit_y     = table_y[k];
                            found         = 1'b1;
                        end
                        table_valid[k] = 1'b0;
                        table_count--;
                        res.removed_count = res.removed_count + 1'b1;
                    end
                end
                if (!found)
                    res.status = pst_pkg::STAT_NO_MATCH;
            end
            pst_pkg::MODE_FIND_Y:
            begin
                for (int k = 0; k < TABLE_SLOTS && !found; k++)
                begin
                    if (table_valid[k] && table_y[k] == r.y_value)
                    begin
                        res.hit_index = k[pst_pkg::IDX_W-1:0];
                        res.hit_x     = table_x[k];
                        res.hit_y     = table_y[k];
                        found         = 1'b1;
                    end
                end
                if (!found)
                    res.status = pst_pkg::STAT_NO_MATCH;
            end
            default:
            begin
            end
        endcase
        res.entries_held = table_count[pst_pkg::COUNT_W-1:0];
    endtask

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Coordinates come half the time from a small pool, so that keys repeat and several
    // slots share one x, and otherwise from the full 16-bit range.
    function automatic logic signed [pst_pkg::COORD_W-1:0] draw_coord();
        logic [31:0] raw;
        raw = $urandom();
        if ($urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return 16'sh0000;
                default: return 16'sh0005;
            endcase
        end
        return raw[pst_pkg::COORD_W-1:0];
    endfunction

    // A filling phase leans on adds until the table runs full; a draining phase leans on
    // removals until it runs empty. Keys for removal and search mostly name live slots.
    function automatic point_req_t draw_request(input bit filling);
        point_req_t r;
        int         live[$];
        int         roll;
        int         pick;
        logic [31:0] raw;
        for (int k = 0; k < TABLE_SLOTS; k++)
            if (table_valid[k])
                live.push_back(k);
        raw          = $urandom();
        r.x_value    = draw_coord();
        r.y_value    = draw_coord();
        r.slot_index = raw[pst_pkg::IDX_W-1:0];
        roll         = $urandom_range(0, 99);
        if (roll < 2)
            r.mode = (roll == 0) ? MODE_SPARE_6 : MODE_SPARE_7;
        else if (roll < (filling ? 60 : 22))
            r.mode = pst_pkg::MODE_ADD;
        else
        begin
            case ($urandom_range(0, 4))
                0: r.mode = pst_pkg::MODE_RM_FIRST;
                1: r.mode = pst_pkg::MODE_RM_LAST;
                2: r.mode = pst_pkg::MODE_RM_IDX;
                3: r.mode = pst_pkg::MODE_RM_X;
                default: r.mode = pst_pkg::MODE_FIND_Y;
            endcase
        end
        if (live.size() > 0 && $urandom_range(0, 99) < 75)
        begin
            pick = live[$urandom_range(0, live.size() - 1)];
            case (r.mode)
                pst_pkg::MODE_RM_IDX: r.slot_index = pick[pst_pkg::IDX_W-1:0];
                pst_pkg::MODE_RM_X:   r.x_value    = table_x[pick];
                pst_pkg::MODE_FIND_Y: r.y_value    = table_y[pick];
                default:
                begin
                end
            endcase
        end
        return r;
    endfunction

    // Drives one request at the falling edge after an optional gap, holds it until the block
    // takes it, then records the result it owes. A typed row overrides the prediction.
    task automatic send_request(input point_req_t r, input bit typed, input slot_result_t want);
        slot_result_t predicted;
        int           gap;
        gap = ((accepted_count % 300) >= 250) ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid      = 1'b1;
        req.mode       = r.mode;
        req.x_value    = r.x_value;
        req.y_value    = r.y_value;
        req.slot_index = r.slot_index;
        do
            @(posedge clk);
        while (!req.ready);
        table_op_predict(r, predicted);
        results_due.push_back(typed ? want : predicted);
        accepted_count++;
    endtask

    task automatic add_row(input logic [pst_pkg::MODE_W-1:0] mode,
                           input logic signed [pst_pkg::COORD_W-1:0] xv,
                           input logic signed [pst_pkg::COORD_W-1:0] yv,
                           input logic [pst_pkg::IDX_W-1:0] idx, input int reps);
        script_row_t row;
        row.req   = '{mode, xv, yv, idx};
        row.reps  = reps;
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_typed_row(input logic [pst_pkg::MODE_W-1:0] mode,
                                 input logic signed [pst_pkg::COORD_W-1:0] xv,
                                 input logic signed [pst_pkg::COORD_W-1:0] yv,
                                 input logic [pst_pkg::IDX_W-1:0] idx, input slot_result_t want);
        script_row_t row;
        row.req   = '{mode, xv, yv, idx};
        row.reps  = 1;
        row.typed = 1'b1;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Result side: ready drops for random stalls, except in calm windows, and stays low for
    // the whole of the long hold-off. It changes only at the falling edge.
    initial
    begin : result_ready_driver
        int stall_left;
        stall_left = 0;
        rsp.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold)
                rsp.ready = 1'b0;
            else if (stall_left > 0)
            begin
                rsp.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp.ready = 1'b1;
                if ((cycle_count % 2000) >= 300 && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Long hold-off on the result side while requests keep coming: the output register fills,
    // the walk in flight finishes and the request side has to stall.
    initial
    begin : result_hold_off
        wait (accepted_count >= 400);
        @(posedge clk);
        rsp_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold = 1'b0;
    end

    // Every collected result is compared field by field with the oldest one owed.
    always @(posedge clk)
    begin
        slot_result_t due;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (results_due.size() == 0)
                report_mismatch("result arrived with no request outstanding");
            else
            begin
                due = results_due.pop_front();
                if (rsp.status !== due.status)
                    report_mismatch($sformatf("status %0d, want %0d", rsp.status, due.status));
                if (rsp.hit_index !== due.hit_index)
                    report_mismatch($sformatf("hit_index %0d, want %0d",
                                              rsp.hit_index, due.hit_index));
                if (rsp.hit_x !== due.hit_x)
                    report_mismatch($sformatf("hit_x %0d, want %0d", rsp.hit_x, due.hit_x));
                if (rsp.hit_y !== due.hit_y)
                    report_mismatch($sformatf("hit_y %0d, want %0d", rsp.hit_y, due.hit_y));
                if (rsp.entries_held !== due.entries_held)
                    report_mismatch($sformatf("entries_held %0d, want %0d",
                                              rsp.entries_held, due.entries_held));
                if (rsp.removed_count !== due.removed_count)
                    report_mismatch($sformatf("removed_count %0d, want %0d",
                                              rsp.removed_count, due.removed_count));
            end
        end
    end

    initial
    begin : stimulus
        bit filling;
        filling        = 1'b0;
        req.valid      = 1'b0;
        req.mode       = pst_pkg::MODE_ADD;
        req.x_value    = '0;
        req.y_value    = '0;
        req.slot_index = '0;
        for (int k = 0; k < TABLE_SLOTS; k++)
        begin
            table_valid[k] = 1'b0;
            table_x[k]     = '0;
            table_y[k]     = '0;
        end
        table_count = 0;

        // Every operation on the empty table after reset: errors, and the spare modes do nothing.
        add_typed_row(pst_pkg::MODE_RM_FIRST, 16'sd0, 16'sd0, 4'd0,
                      '{pst_pkg::STAT_EMPTY, 4'd0, 16'sd0, 16'sd0, 5'd0, 5'd0});
        add_typed_row(pst_pkg::MODE_RM_LAST, 16'sd0, 16'sd0, 4'd0,
                      '{pst_pkg::STAT_EMPTY, 4'd0, 16'sd0, 16'sd0, 5'd0, 5'd0});
        add_typed_row(pst_pkg::MODE_RM_IDX, 16'sd0, 16'sd0, 4'd15,
                      '{pst_pkg::STAT_SLOT_EMPTY, 4'd0, 16'sd0, 16'sd0, 5'd0, 5'd0});
        add_typed_row(pst_pkg::MODE_RM_X, 16'sd0, 16'sd0, 4'd0,
                      '{pst_pkg::STAT_NO_MATCH, 4'd0, 16'sd0, 16'sd0, 5'd0, 5'd0});
        add_typed_row(pst_pkg::MODE_FIND_Y, 16'sd0, 16'sd0, 4'd0,
                      '{pst_pkg::STAT_NO_MATCH, 4'd0, 16'sd0, 16'sd0, 5'd0, 5'd0});
        add_typed_row(MODE_SPARE_6, -16'sd1, -16'sd1, 4'd15,
                      '{pst_pkg::STAT_OK, 4'd0, 16'sd0, 16'sd0, 5'd0, 5'd0});
        add_typed_row(MODE_SPARE_7, -16'sd1, -16'sd1, 4'd15,
                      '{pst_pkg::STAT_OK, 4'd0, 16'sd0, 16'sd0, 5'd0, 5'd0});
        // Coordinate extremes go into the two lowest slots.
        add_typed_row(pst_pkg::MODE_ADD, 16'sh8000, 16'sh7FFF, 4'd0,
                      '{pst_pkg::STAT_OK, 4'd0, 16'sh8000, 16'sh7FFF, 5'd1, 5'd0});
        add_typed_row(pst_pkg::MODE_ADD, 16'sh7FFF, 16'sh8000, 4'd0,
                      '{pst_pkg::STAT_OK, 4'd1, 16'sh7FFF, 16'sh8000, 5'd2, 5'd0});
        add_typed_row(pst_pkg::MODE_FIND_Y, 16'sd0, 16'sh7FFF, 4'd0,
                      '{pst_pkg::STAT_OK, 4'd0, 16'sh8000, 16'sh7FFF, 5'd2, 5'd0});
        // Fill the rest with one shared x, then push once more against the full table.
        add_row(pst_pkg::MODE_ADD, 16'sd5, -16'sd3, 4'd0, TABLE_SLOTS - 2);
        add_typed_row(pst_pkg::MODE_ADD, 16'sd1, 16'sd1, 4'd0,
                      '{pst_pkg::STAT_FULL, 4'd0, 16'sd0, 16'sd0, 5'd16, 5'd0});
        add_typed_row(pst_pkg::MODE_FIND_Y, 16'sd0, 16'sd1234, 4'd0,
                      '{pst_pkg::STAT_NO_MATCH, 4'd0, 16'sd0, 16'sd0, 5'd16, 5'd0});
        add_typed_row(pst_pkg::MODE_RM_IDX, 16'sd0, 16'sd0, 4'd15,
                      '{pst_pkg::STAT_OK, 4'd15, 16'sd5, -16'sd3, 5'd15, 5'd1});
        add_typed_row(pst_pkg::MODE_RM_LAST, 16'sd0, 16'sd0, 4'd0,
                      '{pst_pkg::STAT_OK, 4'd14, 16'sd5, -16'sd3, 5'd14, 5'd1});
        add_typed_row(pst_pkg::MODE_RM_FIRST, 16'sd0, 16'sd0, 4'd0,
                      '{pst_pkg::STAT_OK, 4'd0, 16'sh8000, 16'sh7FFF, 5'd13, 5'd1});
        // One remove by x clears the whole shared-x block at once.
        add_row(pst_pkg::MODE_RM_X, 16'sd5, 16'sd0, 4'd0, 1);
        add_typed_row(pst_pkg::MODE_RM_IDX, 16'sd0, 16'sd0, 4'd0,
                      '{pst_pkg::STAT_SLOT_EMPTY, 4'd0, 16'sd0, 16'sd0, 5'd1, 5'd0});
        add_typed_row(pst_pkg::MODE_RM_IDX, 16'sd0, 16'sd0, 4'd1,
                      '{pst_pkg::STAT_OK, 4'd1, 16'sh7FFF, 16'sh8000, 5'd0, 5'd1});
        add_typed_row(pst_pkg::MODE_RM_X, 16'sd5, 16'sd0, 4'd0,
                      '{pst_pkg::STAT_NO_MATCH, 4'd0, 16'sd0, 16'sd0, 5'd0, 5'd0});
        add_row(pst_pkg::MODE_ADD, -16'sd1, -16'sd1, 4'd0, 1);
        add_row(pst_pkg::MODE_RM_X, -16'sd1, 16'sd0, 4'd0, 1);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            repeat (directed_rows[i].reps)
                send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % PHASE_LENGTH == 0)
                filling = !filling;
            send_request(draw_request(filling), 1'b0, '0);
        end
        @(negedge clk);
        req.valid = 1'b0;

        // Drain, then keep the clock running so that any stray result would still be seen.
        wait (results_due.size() == 0);
        repeat (2 * SCAN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("point_slot_table_top_tb: done, clean");
        else
            $display("point_slot_table_top_tb: done, errors");
        $finish;
    end

    initial
    begin : run_limit
        #(RUN_LIMIT);
        $display("point_slot_table_top_tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
hdl/pst_pkg.sv
hdl/pst_req_if.sv
hdl/pst_rsp_if.sv
hdl/pst_ram.sv
hdl/pst_ctrl.sv
hdl/point_slot_table_top.sv
sim/point_slot_table_top_tb.sv
